FILE: src/fwpp_pkg.sv
// Shared types and codes for the priority-peek request queue.
`timescale 1ns / 1ps

package fwpp_pkg;

  typedef enum logic [1:0] {
    REQ_ENQ   = 2'd0,
    REQ_DEQ   = 2'd1,
    REQ_PEEK  = 2'd2,
    REQ_CLEAR = 2'd3
  } req_type_e;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } status_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_SCAN,
    S_PUSH
  } fsm_state_e;

  typedef struct packed {
    logic [15:0]        id;
    logic signed [15:0] pri;
  } entry_t;

  // Commands broadcast from the controller to every cell of the chain.
  typedef struct packed {
    logic   shift;
    logic   load;
    entry_t new_entry;
  } cell_ctl_t;

endpackage

FILE: src/fwpp_cell.sv
// One storage cell of the queue chain: holds an entry, takes its neighbor's on a shift.
`timescale 1ns / 1ps

module fwpp_cell
  import fwpp_pkg::*;
(
  input  logic      clk_i,
  input  cell_ctl_t ctl_i,
  input  logic      sel_i,
  input  entry_t    next_i,
  output entry_t    entry_o
);

  entry_t entry_q, entry_d;

  always_comb begin
    entry_d = entry_q;
    if (ctl_i.shift) begin
      entry_d = next_i;
    end else if (ctl_i.load && sel_i) begin
      entry_d = ctl_i.new_entry;
    end
  end

  always_ff @(posedge clk_i) begin
    entry_q <= entry_d;
  end

  assign entry_o = entry_q;

endmodule

FILE: src/fwpp_ctrl.sv
// Request sequencer: fill count, priority scan over the rotating chain, result register.
`timescale 1ns / 1ps

module fwpp_ctrl
  import fwpp_pkg::*;
#(
  parameter int DEPTH = 128
) (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       req_valid_i,
  output logic                       req_ready_o,
  input  req_type_e                  req_type_i,
  input  entry_t                     req_entry_i,
  input  entry_t                     head_i,
  output cell_ctl_t                  ctl_o,
  output logic [$clog2(DEPTH)-1:0]   load_idx_o,
  output logic                       res_valid_o,
  input  logic                       res_ready_i,
  output status_e                    res_status_o,
  output logic [15:0]                res_id_o,
  output logic [7:0]                 res_fill_o
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int IW = $clog2(DEPTH);

  fsm_state_e         state_q, state_d;
  req_type_e          req_type_q;
  entry_t             req_entry_q;
  logic [CW-1:0]      count_q, count_d;
  logic [IW-1:0]      scan_q;
  logic signed [15:0] best_pri_q, best_pri_d;
  logic [15:0]        best_id_d;
  status_e            status_q, status_d;
  logic [15:0]        id_q, id_d;
  logic               out_valid_q;
  status_e            out_status_q;
  logic [15:0]        out_id_q;
  logic [7:0]         out_fill_q;

  logic full, empty, scan_last, scan_take, push_ok;

  assign full      = (count_q == CW'(DEPTH));
  assign empty     = (count_q == '0);
  assign scan_last = (scan_q == IW'(DEPTH - 1));
  assign push_ok   = !out_valid_q || res_ready_i;
  // Position n of the rotation shows the entry n places behind the head.
  assign scan_take = (scan_q == '0) ||
                     (({1'b0, scan_q} < (IW + 1)'(count_q)) && (head_i.pri > best_pri_q));

  // Next state.
  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: if (req_valid_i) state_d = S_EXEC;
      S_EXEC: begin
        if (req_type_q == REQ_PEEK && !empty) state_d = S_SCAN;
        else state_d = S_PUSH;
      end
      S_SCAN: if (scan_last) state_d = S_PUSH;
      S_PUSH: if (push_ok) state_d = S_IDLE;
      default: state_d = S_IDLE;
    endcase
  end

  // Outputs of the sequencer and datapath next values.
  always_comb begin
    req_ready_o         = (state_q == S_IDLE);
    ctl_o.shift         = 1'b0;
    ctl_o.load          = 1'b0;
    ctl_o.new_entry     = req_entry_q;
    load_idx_o          = count_q[IW-1:0];
    count_d             = count_q;
    status_d            = status_q;
    id_d                = id_q;
    best_pri_d          = best_pri_q;
    best_id_d           = id_q;
    case (state_q)
      S_EXEC: begin
        status_d = ST_OK;
        id_d     = '0;
        case (req_type_q)
          REQ_ENQ: begin
            if (full) begin
              status_d = ST_FULL;
            end else begin
              ctl_o.load = 1'b1;
              count_d    = count_q + 1'b1;
            end
          end
          REQ_DEQ: begin
            if (empty) begin
              status_d = ST_EMPTY;
            end else begin
              id_d        = head_i.id;
              ctl_o.shift = 1'b1;
              count_d     = count_q - 1'b1;
            end
          end
          REQ_PEEK: begin
            if (empty) status_d = ST_EMPTY;
          end
          REQ_CLEAR: count_d = '0;
          default: status_d = ST_OK;
        endcase
      end
      S_SCAN: begin
        // A full rotation brings every cell back to where it started.
        ctl_o.shift = 1'b1;
        if (scan_take) begin
          best_pri_d = head_i.pri;
          best_id_d  = head_i.id;
        end
        id_d = best_id_d;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      count_q     <= '0;
      scan_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q <= state_d;
      count_q <= count_d;
      if (state_q == S_SCAN) scan_q <= scan_q + 1'b1;
      else scan_q <= '0;
      if (state_q == S_PUSH && push_ok) out_valid_q <= 1'b1;
      else if (res_ready_i) out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && req_valid_i) begin
      req_type_q  <= req_type_i;
      req_entry_q <= req_entry_i;
    end
    status_q   <= status_d;
    id_q       <= id_d;
    best_pri_q <= best_pri_d;
    if (state_q == S_PUSH && push_ok) begin
      out_status_q <= status_q;
      out_id_q     <= id_q;
      out_fill_q   <= 8'(count_q);
    end
  end

  assign res_valid_o  = out_valid_q;
  assign res_status_o = out_status_q;
  assign res_id_o     = out_id_q;
  assign res_fill_o   = out_fill_q;

endmodule

FILE: src/fifo_with_priority_peek_core.sv
// Top level of the priority-peek request queue: a ring of storage cells and its sequencer.
//
//   Port group  | Direction | tdata (low bit up)                  | tuser
//   s_axis      | in        | req_id[15:0], req_priority[31:16]   | req_type[1:0]
//   m_axis      | out       | out_id[15:0], fill_level[23:16]     | status[1:0]
//
// One request at a time: enqueue, dequeue, clear and an empty peek pass through the execute
// and push states and raise m_axis_tvalid when s_axis_tready is high again.
// A peek on a non-empty queue adds a scan state for one full rotation of the cell chain
// past the single comparator at cell 0, which holds the head; a dequeue shifts by one.
// Reset clears the fill count and the control state; cell contents are not reset.
// A new request is taken while the previous result waits; the one after it then stalls.
`timescale 1ns / 1ps

module fifo_with_priority_peek_core
  import fwpp_pkg::*;
#(
  parameter int DEPTH = 128
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [31:0] s_axis_tdata,   // req_id[15:0], req_priority[31:16]
  input  logic [1:0]  s_axis_tuser,   // req_type[1:0]
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [23:0] m_axis_tdata,   // out_id[15:0], fill_level[23:16]
  output logic [1:0]  m_axis_tuser    // status[1:0]
);

  localparam int IW = $clog2(DEPTH);

  cell_ctl_t         ctl;
  logic [IW-1:0]     load_idx;
  entry_t            cells [DEPTH];
  entry_t            req_entry;
  status_e           res_status;
  logic [15:0]       res_id;
  logic [7:0]        res_fill;

  assign req_entry.id  = s_axis_tdata[15:0];
  assign req_entry.pri = s_axis_tdata[31:16];

  fwpp_ctrl #(
    .DEPTH (DEPTH)
  ) u_ctrl (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_valid_i  (s_axis_tvalid),
    .req_ready_o  (s_axis_tready),
    .req_type_i   (req_type_e'(s_axis_tuser)),
    .req_entry_i  (req_entry),
    .head_i       (cells[0]),
    .ctl_o        (ctl),
    .load_idx_o   (load_idx),
    .res_valid_o  (m_axis_tvalid),
    .res_ready_i  (m_axis_tready),
    .res_status_o (res_status),
    .res_id_o     (res_id),
    .res_fill_o   (res_fill)
  );

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    fwpp_cell u_cell (
      .clk_i   (clk_i),
      .ctl_i   (ctl),
      .sel_i   (load_idx == IW'(i)),
      .next_i  (cells[(i + 1) % DEPTH]),
      .entry_o (cells[i])
    );
  end

  assign m_axis_tdata = {res_fill, res_id};
  assign m_axis_tuser = res_status;

endmodule

FILE: test/fifo_with_priority_peek_core_test.sv
// Self-checking stream testbench for the priority-peek request queue core.
`timescale 1ns / 1ps

module fifo_with_priority_peek_core_test;
  import fwpp_pkg::*;

  localparam int DEPTH = 128;
  localparam int CYCLE_LIMIT = 1000000;
  localparam int RANDOM_REQUESTS = 1000;

  typedef struct {
    status_e     status;
    logic [15:0] id;
    logic [7:0]  fill;
  } queue_result_t;

  // Tracks the queue contents and holds the results still owed by the core.
  class priority_queue_scoreboard;
    localparam int QDEPTH = 128;
    logic [15:0]        id_mem [QDEPTH];
    logic signed [15:0] pri_mem [QDEPTH];
    int unsigned        head_pos, tail_pos, fill_count;
    queue_result_t      owed_results [$];
    int                 mismatches, checked, full_refusals, empty_refusals, peeks, peak_fill;

    function new();
      head_pos = 0;
      tail_pos = 0;
      fill_count = 0;
      mismatches = 0;
      checked = 0;
      full_refusals = 0;
      empty_refusals = 0;
      peeks = 0;
      peak_fill = 0;
    endfunction

    task report_mismatch(input string what);
      mismatches++;
      if (mismatches <= 100) $display("mismatch at %0t: %s", $realtime, what);
    endtask

    function int owed();
      return owed_results.size();
    endfunction

    // Applies one accepted request to the tracked queue and records the result it owes.
    function status_e note_request(input req_type_e kind, input logic [15:0] id,
                                   input logic [15:0] pri);
      queue_result_t      r;
      int unsigned        pos, best;
      logic signed [15:0] best_pri;
      r.status = ST_OK;
      r.id = '0;
      case (kind)
        REQ_ENQ: begin
          if (fill_count >= QDEPTH) begin
            r.status = ST_FULL;
          end else begin
            id_mem[tail_pos] = id;
            pri_mem[tail_pos] = pri;
            tail_pos = (tail_pos + 1) % QDEPTH;
            fill_count++;
          end
        end
        REQ_DEQ: begin
          if (fill_count == 0) begin
            r.status = ST_EMPTY;
          end else begin
            r.id = id_mem[head_pos];
            head_pos = (head_pos + 1) % QDEPTH;
            fill_count--;
          end
        end
        REQ_PEEK: begin
          peeks++;
          if (fill_count == 0) begin
            r.status = ST_EMPTY;
          end else begin
            pos = head_pos;
            best = head_pos;
            best_pri = pri_mem[head_pos];
            // Strictly greater keeps the entry nearest the head on a tie.
            for (int n = 1; n < fill_count; n++) begin
              pos = (pos + 1) % QDEPTH;
              if (pri_mem[pos] > best_pri) begin
                best_pri = pri_mem[pos];
                best = pos;
              end
            end
            r.id = id_mem[best];
          end
        end
        default: begin
          head_pos = 0;
          tail_pos = 0;
          fill_count = 0;
        end
      endcase
      if (r.status == ST_FULL) full_refusals++;
      if (r.status == ST_EMPTY) empty_refusals++;
      if (fill_count > peak_fill) peak_fill = fill_count;
      r.fill = 8'(fill_count);
      owed_results.push_back(r);
      return r.status;
    endfunction

    task check_result(input status_e status, input logic [15:0] id, input logic [7:0] fill);
      queue_result_t r;
      if (owed_results.size() == 0) begin
        report_mismatch($sformatf("result st=%0d id=%h fill=%0d with none owed",
                                  status, id, fill));
      end else begin
        r = owed_results.pop_front();
        checked++;
        if (status !== r.status)
          report_mismatch($sformatf("status %0d, wanted %0d", status, r.status));
        if (id !== r.id)
          report_mismatch($sformatf("out_id %h, wanted %h", id, r.id));
        if (fill !== r.fill)
          report_mismatch($sformatf("fill_level %0d, wanted %0d", fill, r.fill));
      end
    endtask
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [31:0] s_axis_tdata = '0;
  logic [1:0]  s_axis_tuser = '0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [23:0] m_axis_tdata;
  logic [1:0]  m_axis_tuser;

  priority_queue_scoreboard sb = new();
  int  cycle_count = 0;
  int  sink_hold = 0;
  bit  src_eager = 1'b0;
  bit  sink_eager = 1'b0;

  fifo_with_priority_peek_core #(.DEPTH(DEPTH)) uut (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results owed", cycle_count, sb.owed());
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  // Mostly short gaps, now and then a long one.
  function automatic int pick_gap(input bit eager);
    int r;
    r = $urandom_range(0, 99);
    if (eager || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Receiver: may stall for a random gap after each accepted word, with eager stretches toggled at random.
  always @(negedge clk_i) begin
    if (sink_hold > 0) begin
      sink_hold <= sink_hold - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      sb.check_result(status_e'(m_axis_tuser), m_axis_tdata[15:0], m_axis_tdata[23:16]);
      if ($urandom_range(0, 149) == 0) sink_eager = !sink_eager;
      sink_hold = pick_gap(sink_eager);
    end
  end

  // Offers one request after a random gap and returns once it has been accepted.
  task automatic send_request(input req_type_e kind, input logic [15:0] id,
                              input logic [15:0] pri, output status_e outcome);
    int gap;
    gap = pick_gap(src_eager);
    repeat (gap) begin
      @(negedge clk_i);
      s_axis_tvalid <= 1'b0;
    end
    @(negedge clk_i);
    s_axis_tvalid <= 1'b1;
    s_axis_tdata <= {pri, id};
    s_axis_tuser <= kind;
    do @(posedge clk_i); while (!s_axis_tready);
    outcome = sb.note_request(kind, id, pri);
  endtask

  initial begin : stimulus
    status_e     outcome;
    req_type_e   kind;
    logic [15:0] id, pri;
    int          mode, len, pri_style, r, sent;
    sent = 0;
    repeat (11) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: empty refusals, extreme fields, tie toward the head, clear, lone minimum.
    send_request(REQ_PEEK, 16'hFFFF, 16'h7FFF, outcome);
    send_request(REQ_DEQ, 16'hFFFF, 16'h8000, outcome);
    send_request(REQ_CLEAR, 16'hFFFF, 16'hFFFF, outcome);
    send_request(REQ_ENQ, 16'h0000, 16'h8000, outcome);
    send_request(REQ_ENQ, 16'hFFFF, 16'h7FFF, outcome);
    send_request(REQ_ENQ, 16'h1234, 16'h7FFF, outcome);
    send_request(REQ_ENQ, 16'h5A5A, 16'hFFFF, outcome);
    send_request(REQ_PEEK, 16'h0000, 16'h0000, outcome);
    send_request(REQ_DEQ, 16'h0000, 16'h0000, outcome);
    send_request(REQ_PEEK, 16'hAAAA, 16'h5555, outcome);
    send_request(REQ_DEQ, 16'h0000, 16'h0000, outcome);
    send_request(REQ_PEEK, 16'h0000, 16'h0000, outcome);
    send_request(REQ_CLEAR, 16'h0000, 16'h0000, outcome);
    send_request(REQ_PEEK, 16'h0000, 16'h0000, outcome);
    send_request(REQ_DEQ, 16'h0000, 16'h0000, outcome);
    send_request(REQ_ENQ, 16'hA5A5, 16'h8000, outcome);
    send_request(REQ_PEEK, 16'hFFFF, 16'h7FFF, outcome);
    send_request(REQ_ENQ, 16'h3C3C, 16'h8000, outcome);
    send_request(REQ_PEEK, 16'h0000, 16'h0000, outcome);
    send_request(REQ_DEQ, 16'h0000, 16'h0000, outcome);
    send_request(REQ_DEQ, 16'h0000, 16'h0000, outcome);
    send_request(REQ_ENQ, 16'h0001, 16'h0000, outcome);
    send_request(REQ_PEEK, 16'h0000, 16'h0000, outcome);
    send_request(REQ_CLEAR, 16'h0000, 16'h0000, outcome);
    sent = 24;

    // Random phases: filling runs can reach the full queue, draining runs can empty it.
    while (sent < RANDOM_REQUESTS) begin
      mode = $urandom_range(0, 3);
      len = $urandom_range(20, 200);
      if (len > RANDOM_REQUESTS - sent) len = RANDOM_REQUESTS - sent;
      pri_style = $urandom_range(0, 2);
      src_eager = ($urandom_range(0, 3) == 0);
      repeat (len) begin
        r = $urandom_range(0, 99);
        case (mode)
          0: kind = (r < 82) ? REQ_ENQ : (r < 92) ? REQ_PEEK : (r < 99) ? REQ_DEQ : REQ_CLEAR;
          1: kind = (r < 15) ? REQ_ENQ : (r < 30) ? REQ_PEEK : (r < 99) ? REQ_DEQ : REQ_CLEAR;
          2: kind = (r < 40) ? REQ_ENQ : (r < 65) ? REQ_PEEK : (r < 95) ? REQ_DEQ : REQ_CLEAR;
          default: kind = req_type_e'($urandom_range(0, 3));
        endcase
        id = 16'($urandom);
        case (pri_style)
          0: pri = 16'($urandom);
          1: pri = 16'($urandom_range(0, 4)) - 16'd2;  // Narrow range forces many ties.
          default: begin
            case ($urandom_range(0, 3))
              0: pri = 16'h8000;
              1: pri = 16'h7FFF;
              2: pri = 16'hFFFF;
              default: pri = 16'h0000;
            endcase
          end
        endcase
        send_request(kind, id, pri, outcome);
        sent++;
      end
    end

    @(negedge clk_i);
    s_axis_tvalid <= 1'b0;
    while (sb.owed() != 0) @(posedge clk_i);
    // Long enough for a full peek scan, to catch a stray extra word.
    repeat (DEPTH + 20) @(posedge clk_i);

    $display("%0d requests sent, %0d results checked, %0d peeks, peak fill %0d",
             sent, sb.checked, sb.peeks, sb.peak_fill);
    $display("%0d full refusals, %0d empty refusals, %0d mismatches",
             sb.full_refusals, sb.empty_refusals, sb.mismatches);
    if (sb.mismatches == 0 && sb.owed() == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
